/* rtl/yrsa_pkg.sv */
// Shared types, constants and helper functions for the yaw rate to steering angle block.
package yrsa_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FRAC_BITS_DEF    = 12;

   // Field and register widths.
   localparam int SPEED_W = 16;
   localparam int RATE_W  = 16;
   localparam int ANGLE_W = 15;
   localparam int WB_W    = 14;
   localparam int MS_W    = 15;
   localparam int MA_W    = 14;

   // CORDIC datapath width; covers the largest vector after the gain.
   localparam int XY_W   = 32;
   // Signed product of wheelbase and yaw rate.
   localparam int PROD_W = WB_W + 1 + RATE_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_WHEELBASE   = 2'd0;
   localparam logic [1:0] REG_SPEED_FLOOR = 2'd1;
   localparam logic [1:0] REG_MAX_ANGLE   = 2'd2;

   localparam logic [WB_W-1:0] WHEELBASE_RST   = WB_W'(606);
   localparam logic [MS_W-1:0] SPEED_FLOOR_RST = MS_W'(410);
   localparam logic [MA_W-1:0] MAX_ANGLE_RST   = MA_W'(3000);

   // 18000/pi in Q16.
   localparam int CDEG_K_W = 29;
   localparam logic [CDEG_K_W-1:0] RAD_TO_CDEG_Q16 = CDEG_K_W'(375493621);

   // Arctangent of 2^-i in Q30.
   localparam int ATAN_ROM_DEPTH = 24;
   localparam longint ATAN_ROM_Q30 [ATAN_ROM_DEPTH] = '{
      64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159,
      64'd67021687,  64'd33543516,  64'd16775851,  64'd8388437,
      64'd4194283,   64'd2097149,   64'd1048576,   64'd524288,
      64'd262144,    64'd131072,    64'd65536,     64'd32768,
      64'd16384,     64'd8192,      64'd4096,      64'd2048,
      64'd1024,      64'd512,       64'd256,       64'd128
   };

   // Control and pass-through fields that travel alongside the datapath.
   typedef struct packed {
      logic                      valid;
      logic                      stop;
      logic                      conv;
      logic                      yzero;
      logic signed [SPEED_W-1:0] speed;
      logic signed [RATE_W-1:0]  rate;
   } cmd_type;

   // Step arctangent rounded half up from Q30 to the requested fraction.
   function automatic longint atan_const(input int step, input int frac);
      longint sh;
      sh = longint'(30 - frac);
      return (ATAN_ROM_Q30[step] + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

endpackage

/* rtl/yrsa_front.sv */
// Input stage: scales the yaw rate by the wheelbase and forms the CORDIC start vector.
module yrsa_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 mode,
   input  logic signed [yrsa_pkg::SPEED_W-1:0]  linear_speed,
   input  logic signed [yrsa_pkg::RATE_W-1:0]   angular_rate,
   input  logic [yrsa_pkg::WB_W-1:0]            wheelbase,
   input  logic [yrsa_pkg::MS_W-1:0]            speed_floor,
   output yrsa_pkg::cmd_type                    dn_cmd,
   output logic signed [yrsa_pkg::XY_W-1:0]     dn_x,
   output logic signed [yrsa_pkg::XY_W-1:0]     dn_y
);
   import yrsa_pkg::*;

   localparam int AV_W = SPEED_W + 1;

   cmd_type                   s1_cmd_ff, s1_cmd_in;
   logic signed [PROD_W-1:0]  s1_prod_ff, s1_prod_in;
   logic [AV_W-1:0]           av_now;

   cmd_type                   s2_cmd_ff, s2_cmd_in;
   logic signed [XY_W-1:0]    s2_x_ff, s2_x_in;
   logic signed [XY_W-1:0]    s2_y_ff, s2_y_in;
   logic [AV_W-1:0]           av_s1;
   logic signed [XY_W-1:0]    prod_ext;

   always_comb begin
      av_now = linear_speed[SPEED_W-1] ? AV_W'(-{linear_speed[SPEED_W-1], linear_speed})
                                       : AV_W'({linear_speed[SPEED_W-1], linear_speed});
      s1_cmd_in.valid = start;
      s1_cmd_in.stop  = mode;
      s1_cmd_in.conv  = (av_now >= AV_W'(speed_floor));
      s1_cmd_in.yzero = 1'b0;
      s1_cmd_in.speed = linear_speed;
      s1_cmd_in.rate  = angular_rate;
      s1_prod_in      = $signed({1'b0, wheelbase}) * angular_rate;
   end

   always_comb begin
      av_s1 = s1_cmd_ff.speed[SPEED_W-1]
              ? AV_W'(-{s1_cmd_ff.speed[SPEED_W-1], s1_cmd_ff.speed})
              : AV_W'({s1_cmd_ff.speed[SPEED_W-1], s1_cmd_ff.speed});
      prod_ext        = XY_W'(s1_prod_ff);
      s2_cmd_in       = s1_cmd_ff;
      s2_cmd_in.yzero = (s1_prod_ff == '0);
      s2_x_in         = XY_W'({av_s1, 12'b0});
      s2_y_in         = s1_cmd_ff.speed[SPEED_W-1] ? -prod_ext : prod_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_cmd_ff.valid <= 1'b0;
         s2_cmd_ff.valid <= 1'b0;
      end else begin
         s1_cmd_ff <= s1_cmd_in;
         s2_cmd_ff <= s2_cmd_in;
      end
      s1_prod_ff <= s1_prod_in;
      s2_x_ff    <= s2_x_in;
      s2_y_ff    <= s2_y_in;
   end

   assign dn_cmd = s2_cmd_ff;
   assign dn_x   = s2_x_ff;
   assign dn_y   = s2_y_ff;

endmodule

/* rtl/yrsa_cordic_cell.sv */
// One vectoring CORDIC step with its own output register.
module yrsa_cordic_cell #(
   parameter int STEP      = 0,
   parameter int FRAC_BITS = yrsa_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  yrsa_pkg::cmd_type                 up_cmd,
   input  logic signed [yrsa_pkg::XY_W-1:0]  up_x,
   input  logic signed [yrsa_pkg::XY_W-1:0]  up_y,
   input  logic signed [FRAC_BITS+2:0]       up_z,
   output yrsa_pkg::cmd_type                 dn_cmd,
   output logic signed [yrsa_pkg::XY_W-1:0]  dn_x,
   output logic signed [yrsa_pkg::XY_W-1:0]  dn_y,
   output logic signed [FRAC_BITS+2:0]       dn_z
);
   import yrsa_pkg::*;

   localparam int Z_W = FRAC_BITS + 3;
   localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(atan_const(STEP, FRAC_BITS));

   cmd_type                 cmd_ff;
   logic signed [XY_W-1:0]  x_ff, x_in;
   logic signed [XY_W-1:0]  y_ff, y_in;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic signed [XY_W-1:0]  xs, ys;
   logic                    rot_down;

   always_comb begin
      xs       = up_x >>> STEP;
      ys       = up_y >>> STEP;
      rot_down = ~up_y[XY_W-1];
      if (rot_down) begin
         x_in = up_x + ys;
         y_in = up_y - xs;
         z_in = up_z + ATAN_STEP;
      end else begin
         x_in = up_x - ys;
         y_in = up_y + xs;
         z_in = up_z - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff.valid <= 1'b0;
      end else begin
         cmd_ff <= up_cmd;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign dn_cmd = cmd_ff;
   assign dn_x   = x_ff;
   assign dn_y   = y_ff;
   assign dn_z   = z_ff;

endmodule

/* rtl/yrsa_back.sv */
// Output stages: picks the angle, converts radians to centidegrees and clamps.
module yrsa_back #(
   parameter int FRAC_BITS = yrsa_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  yrsa_pkg::cmd_type                    up_cmd,
   input  logic signed [FRAC_BITS+2:0]          up_z,
   input  logic [yrsa_pkg::MA_W-1:0]            max_angle,
   output logic                                 rsp_valid,
   output logic signed [yrsa_pkg::SPEED_W-1:0]  rsp_speed_out,
   output logic signed [yrsa_pkg::ANGLE_W-1:0]  rsp_steering_angle
);
   import yrsa_pkg::*;

   localparam int RAD_W    = FRAC_BITS + 4;
   localparam int UP_SH    = (FRAC_BITS >= 12) ? FRAC_BITS - 12 : 0;
   localparam int DN_SH    = (FRAC_BITS < 12) ? 12 - FRAC_BITS : 0;
   localparam int PASS_W   = RATE_W + UP_SH;
   localparam int MUL_W    = RAD_W + CDEG_K_W;
   localparam int RND_W    = MUL_W + 1;
   localparam int CDEG_SH  = FRAC_BITS + 16;

   // Stage 1: angle in radians as sign and magnitude.
   logic signed [RAD_W-1:0]   rad;
   logic signed [PASS_W-1:0]  pass_wide;
   logic signed [RAD_W-1:0]   rad_pass;
   logic                      p1_valid_ff;
   logic                      p1_stop_ff;
   logic signed [SPEED_W-1:0] p1_speed_ff;
   logic                      p1_neg_ff, p1_neg_in;
   logic [RAD_W-1:0]          p1_mag_ff, p1_mag_in;

   // Stage 2: product with the centidegree scale.
   logic                      p2_valid_ff;
   logic                      p2_stop_ff;
   logic signed [SPEED_W-1:0] p2_speed_ff;
   logic                      p2_neg_ff;
   logic [MUL_W-1:0]          p2_prod_ff, p2_prod_in;

   // Stage 3: rounding, clamp and output register.
   logic [RND_W-1:0]          rnd;
   logic [RND_W-1:0]          cdeg_mag;
   logic [MA_W-1:0]           clamped;
   logic signed [MA_W+1:0]    signed_cdeg;
   logic                      valid_ff;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;

   always_comb begin
      // The yaw rate is widened before rescaling so that no bits are lost.
      pass_wide = PASS_W'(up_cmd.rate) <<< UP_SH;
      rad_pass  = RAD_W'(pass_wide >>> DN_SH);
      if (up_cmd.stop) begin
         rad = '0;
      end else if (up_cmd.conv) begin
         // A zero numerator gives a zero angle whatever the CORDIC settled on.
         rad = up_cmd.yzero ? '0 : RAD_W'(up_z);
      end else begin
         rad = rad_pass;
      end
      p1_neg_in = rad[RAD_W-1];
      p1_mag_in = p1_neg_in ? RAD_W'(-rad) : RAD_W'(rad);
   end

   assign p2_prod_in = MUL_W'(p1_mag_ff) * MUL_W'(RAD_TO_CDEG_Q16);

   always_comb begin
      rnd         = RND_W'(p2_prod_ff) + (RND_W'(1) << (CDEG_SH - 1));
      cdeg_mag    = rnd >> CDEG_SH;
      clamped     = (cdeg_mag > RND_W'(max_angle)) ? max_angle : MA_W'(cdeg_mag);
      signed_cdeg = p2_neg_ff ? -$signed({2'b00, clamped}) : $signed({2'b00, clamped});
      speed_in    = p2_stop_ff ? '0 : p2_speed_ff;
      angle_in    = ANGLE_W'(signed_cdeg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         p1_valid_ff <= up_cmd.valid;
         p2_valid_ff <= p1_valid_ff;
         valid_ff    <= p2_valid_ff;
      end
      p1_stop_ff  <= up_cmd.stop;
      p1_speed_ff <= up_cmd.speed;
      p1_neg_ff   <= p1_neg_in;
      p1_mag_ff   <= p1_mag_in;
      p2_stop_ff  <= p1_stop_ff;
      p2_speed_ff <= p1_speed_ff;
      p2_neg_ff   <= p1_neg_ff;
      p2_prod_ff  <= p2_prod_in;
      speed_ff    <= speed_in;
      angle_ff    <= angle_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_speed_out      = speed_ff;
   assign rsp_steering_angle = angle_ff;

endmodule

/* rtl/yaw_rate_to_steering_angle_top.sv */
// Top level: register file, input stage, chain of CORDIC cells and output stages.
//
// A command is taken at each rising edge at which start is high; busy is
// always low, so a new command can be issued in every cycle. Each command
// carries a mode bit, a forward speed and a yaw rate, both signed Q3.12.
// Exactly one transaction comes back per command, in order, on the rsp_
// ports for one cycle marked by rsp_valid. Between command and result lie
// two input stages (wheelbase product, start vector), one register per
// CORDIC cell, and three output stages (sign and magnitude, centidegree
// product, rounding and clamp).
// Throughput is one transaction per cycle, set by the pipelined CORDIC chain.
// The receiver has no means to hold results back; it must take each result
// in the cycle it is shown.
// Wheelbase, minimum speed and maximum angle sit on the APB port at byte
// addresses 0, 4 and 8; write them only while no command is in flight.
// Reset empties the pipeline and loads the default register values.
module yaw_rate_to_steering_angle_top #(
   parameter int CORDIC_STEPS = yrsa_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = yrsa_pkg::FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_mode,
   input  logic signed [yrsa_pkg::SPEED_W-1:0]     req_linear_speed,
   input  logic signed [yrsa_pkg::RATE_W-1:0]      req_angular_rate,
   output logic                                    rsp_valid,
   output logic signed [yrsa_pkg::SPEED_W-1:0]     rsp_speed_out,
   output logic signed [yrsa_pkg::ANGLE_W-1:0]     rsp_steering_angle,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [yrsa_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [yrsa_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [yrsa_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);
   import yrsa_pkg::*;

   localparam int Z_W = FRAC_BITS + 3;

   logic [WB_W-1:0] wheelbase_ff, wheelbase_in;
   logic [MS_W-1:0] speed_floor_ff, speed_floor_in;
   logic [MA_W-1:0] max_angle_ff, max_angle_in;
   logic            csr_write;
   logic [1:0]      csr_index;

   cmd_type                 cmd_chain [CORDIC_STEPS+1];
   logic signed [XY_W-1:0]  x_chain   [CORDIC_STEPS+1];
   logic signed [XY_W-1:0]  y_chain   [CORDIC_STEPS+1];
   logic signed [Z_W-1:0]   z_chain   [CORDIC_STEPS+1];

   assign busy      = 1'b0;
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      wheelbase_in   = wheelbase_ff;
      speed_floor_in = speed_floor_ff;
      max_angle_in   = max_angle_ff;
      if (csr_write) begin
         case (csr_index)
            REG_WHEELBASE: begin
               wheelbase_in = pwdata[WB_W-1:0];
            end
            REG_SPEED_FLOOR: begin
               speed_floor_in = pwdata[MS_W-1:0];
            end
            REG_MAX_ANGLE: begin
               max_angle_in = pwdata[MA_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WHEELBASE:   prdata = CSR_DATA_W'(wheelbase_ff);
         REG_SPEED_FLOOR: prdata = CSR_DATA_W'(speed_floor_ff);
         REG_MAX_ANGLE:   prdata = CSR_DATA_W'(max_angle_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheelbase_ff   <= WHEELBASE_RST;
         speed_floor_ff <= SPEED_FLOOR_RST;
         max_angle_ff   <= MAX_ANGLE_RST;
      end else begin
         wheelbase_ff   <= wheelbase_in;
         speed_floor_ff <= speed_floor_in;
         max_angle_ff   <= max_angle_in;
      end
   end

   yrsa_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .mode         (req_mode),
      .linear_speed (req_linear_speed),
      .angular_rate (req_angular_rate),
      .wheelbase    (wheelbase_ff),
      .speed_floor  (speed_floor_ff),
      .dn_cmd       (cmd_chain[0]),
      .dn_x         (x_chain[0]),
      .dn_y         (y_chain[0])
   );

   assign z_chain[0] = '0;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      yrsa_cordic_cell #(
         .STEP      (i),
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .up_cmd (cmd_chain[i]),
         .up_x   (x_chain[i]),
         .up_y   (y_chain[i]),
         .up_z   (z_chain[i]),
         .dn_cmd (cmd_chain[i+1]),
         .dn_x   (x_chain[i+1]),
         .dn_y   (y_chain[i+1]),
         .dn_z   (z_chain[i+1])
      );
   end

   yrsa_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .up_cmd             (cmd_chain[CORDIC_STEPS]),
      .up_z               (z_chain[CORDIC_STEPS]),
      .max_angle          (max_angle_ff),
      .rsp_valid          (rsp_valid),
      .rsp_speed_out      (rsp_speed_out),
      .rsp_steering_angle (rsp_steering_angle)
   );

endmodule
